// ===== rtl/tebs_pkg.sv =====
// Shared constants, command codes and control structs for the blend smoother.
package tebs_pkg;

    // Geometry of the position vector
    localparam int AXES       = 3;
    localparam int POS_BITS   = 32;
    localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;

    // Field widths
    localparam int OP_W       = 2;
    localparam int TIME_W     = 32;
    localparam int DLY_W      = 16;
    localparam int FRAC_W     = 18;
    localparam int DIST_W     = 31;
    localparam int GAIN_W     = 17;
    localparam int IDX_W      = 2;
    localparam int FRAC_SH    = 16;

    // Shared multiplier and divider
    localparam int MUL_W      = (POS_BITS + 1 > DIST_W + 1) ? POS_BITS + 1 : DIST_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIV_W      = TIME_W + FRAC_SH;
    localparam int DCNT_W     = $clog2(DIV_W);

    // Stream widths
    localparam int IN_RAW_W   = TIME_W + 2 * AXES * POS_BITS;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = AXES * POS_BITS;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_GOAL   = 2'd1;
    localparam logic [OP_W-1:0] OP_SNAP   = 2'd2;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DELAY    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_FRAC = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_DIST = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DLY_W-1:0]  DELAY_RST    = 16'd100;
    localparam logic [FRAC_W-1:0] MAX_FRAC_RST = 18'd98304;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 31'd81920;

    // Gain and alpha constants
    localparam logic [DLY_W-1:0]  GAIN_D_LO    = 16'd100;
    localparam logic [DLY_W-1:0]  GAIN_D_HI    = 16'd400;
    // Gain ramp (d - 100) * 4096 / 25 as a multiply by ceil(2^31 / 25) and a shift by 19
    localparam logic [26:0]       GAIN_RECIP   = 27'd85899346;
    localparam int                GAIN_SH      = 19;
    localparam logic [GAIN_W-1:0] GAIN_LO      = 17'd16384;
    localparam logic [GAIN_W-1:0] GAIN_HI      = 17'd65536;
    localparam logic [FRAC_W-1:0] ALPHA_ONE    = 18'd65536;
    localparam logic [FRAC_W-1:0] ALPHA_SAT    = 18'h3FFFF;
    localparam logic [PROD_W-1:0] ROUND_HALF   = PROD_W'(32768);

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR,
        CMD_SQ,
        CMD_SQACC,
        CMD_MD,
        CMD_FAR,
        CMD_DIVT,
        CMD_GMUL,
        CMD_DIVSTEP,
        CMD_ALPHA,
        CMD_SNAP,
        CMD_STMUL,
        CMD_STADD,
        CMD_GAIN,
        CMD_EMUL,
        CMD_EADD,
        CMD_GDONE,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [AXIS_W-1:0] axis;
    } ctl_t;

    typedef struct packed {
        logic            active;
        logic            far;
        logic [OP_W-1:0] op;
        logic            out_busy;
    } stat_t;

endpackage

// ===== rtl/tebs_div.sv =====
// Restoring divider, one quotient bit per step.
module tebs_div
    import tebs_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DLY_W-1:0]  divisor,
    output logic [DIV_W-1:0]  quotient
);

    logic [DLY_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DLY_W-1:0] dvs_reg;
    logic [DLY_W:0]   shifted;
    logic [DLY_W:0]   trial;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= fits ? trial[DLY_W-1:0] : shifted[DLY_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;

endmodule

// ===== rtl/tebs_datapath.sv =====
// Datapath: state, configuration, shared multiplier, divider and output register.
module tebs_datapath
    import tebs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  ctl,
    output stat_t                 stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  cfg_valid,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [DIST_W-1:0]     cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    // Control state
    logic                active_reg;
    logic                m_valid_reg;
    logic [DLY_W-1:0]    delay_reg;
    logic [FRAC_W-1:0]   max_frac_reg;
    logic [DIST_W-1:0]   max_dist_reg;

    // Payload state
    logic [OP_W-1:0]     op_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [POS_BITS-1:0] p_reg    [AXES];
    logic [POS_BITS-1:0] gin_reg  [AXES];
    logic [POS_BITS-1:0] goal_reg [AXES];
    logic [POS_BITS-1:0] err_reg  [AXES];
    logic [POS_BITS-1:0] out_p_reg [AXES];
    logic [TIME_W-1:0]   start_reg;
    logic [FRAC_W-1:0]   last_reg;
    logic [FRAC_W:0]     delta_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic                far_reg;
    logic                snapped_reg;
    logic                out_active_reg;
    logic                out_snapped_reg;

    // Combinational values
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic [POS_BITS:0]        diff;
    logic [POS_BITS:0]        adiff;
    logic [PROD_W-1:0]        rnd;
    logic [PROD_W-POS_BITS-FRAC_SH:0] rnd_hi;
    logic [POS_BITS-1:0]      sat_val;
    logic [DIV_W-1:0]         quot;
    logic [DIV_W-1:0]         div_dividend;
    logic [DLY_W-1:0]         div_divisor;
    logic [DLY_W-1:0]         d_off;
    logic [FRAC_W-1:0]        alpha_q;
    logic [FRAC_W-1:0]        alpha;

    // Operand selection for the shared multiplier
    always_comb
    begin
        diff  = {p_reg[ctl.axis][POS_BITS-1], p_reg[ctl.axis]}
              - {goal_reg[ctl.axis][POS_BITS-1], goal_reg[ctl.axis]};
        adiff = diff[POS_BITS] ? (~diff + 1'b1) : diff;
        d_off = delay_reg - GAIN_D_LO;
        mul_a = '0;
        mul_b = '0;
        case (ctl.cmd)
            CMD_SQ:
            begin
                mul_a = MUL_W'(adiff);
                mul_b = MUL_W'(adiff);
            end
            CMD_MD:
            begin
                mul_a = MUL_W'(max_dist_reg);
                mul_b = MUL_W'(max_dist_reg);
            end
            CMD_GMUL:
            begin
                mul_a = MUL_W'(d_off);
                mul_b = MUL_W'(GAIN_RECIP);
            end
            CMD_STMUL:
            begin
                mul_a = MUL_W'($signed(err_reg[ctl.axis]));
                mul_b = MUL_W'($signed(delta_reg));
            end
            CMD_EMUL:
            begin
                mul_a = MUL_W'($signed({gin_reg[ctl.axis][POS_BITS-1], gin_reg[ctl.axis]}
                      - {p_reg[ctl.axis][POS_BITS-1], p_reg[ctl.axis]}));
                mul_b = MUL_W'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of the Q16 product and saturation to the position range
    always_comb
    begin
        rnd     = prod_reg + ROUND_HALF;
        rnd_hi  = rnd[PROD_W-1:FRAC_SH+POS_BITS-1];
        if ((&rnd_hi) || !(|rnd_hi))
            sat_val = rnd[FRAC_SH +: POS_BITS];
        else if (rnd[PROD_W-1])
            sat_val = {1'b1, {(POS_BITS-1){1'b0}}};
        else
            sat_val = {1'b0, {(POS_BITS-1){1'b1}}};
    end

    // Divider operands: elapsed time over the blend duration
    always_comb
    begin
        div_dividend = {now_reg - start_reg, {FRAC_SH{1'b0}}};
        div_divisor  = delay_reg;
    end

    tebs_div u_div
    (
        .clk      (clk),
        .load     (ctl.cmd == CMD_DIVT),
        .step     (ctl.cmd == CMD_DIVSTEP),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quot)
    );

    // Alpha from the quotient, clamped to the ceiling
    always_comb
    begin
        if (delay_reg == '0)
            alpha_q = ALPHA_ONE;
        else if (|quot[DIV_W-1:FRAC_W])
            alpha_q = ALPHA_SAT;
        else
            alpha_q = quot[FRAC_W-1:0];
        alpha = (alpha_q > max_frac_reg) ? max_frac_reg : alpha_q;
    end

    // Control registers: configuration, blend flag, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            delay_reg    <= DELAY_RST;
            max_frac_reg <= MAX_FRAC_RST;
            max_dist_reg <= MAX_DIST_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_DELAY:    delay_reg    <= cfg_data[DLY_W-1:0];
                    CFG_MAX_FRAC: max_frac_reg <= cfg_data[FRAC_W-1:0];
                    CFG_MAX_DIST: max_dist_reg <= cfg_data;
                    default:      ;
                endcase
            end
            case (ctl.cmd)
                CMD_CLEAR: active_reg <= 1'b0;
                CMD_SNAP:  active_reg <= 1'b0;
                CMD_GDONE: active_reg <= 1'b1;
                CMD_ALPHA:
                begin
                    if (alpha == max_frac_reg)
                        active_reg <= 1'b0;
                end
                default: ;
            endcase
            if (ctl.cmd == CMD_OUT)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a * mul_b);
        case (ctl.cmd)
            CMD_LOAD:
            begin
                op_reg      <= s_tuser;
                now_reg     <= s_tdata[TIME_W-1:0];
                acc_reg     <= '0;
                snapped_reg <= 1'b0;
                for (int i = 0; i < AXES; i++)
                begin
                    p_reg[i]   <= s_tdata[TIME_W + i*POS_BITS +: POS_BITS];
                    gin_reg[i] <= s_tdata[TIME_W + (AXES+i)*POS_BITS +: POS_BITS];
                end
            end
            CMD_CLEAR:
            begin
                if (op_reg == OP_SNAP && active_reg)
                begin
                    snapped_reg <= 1'b1;
                    for (int i = 0; i < AXES; i++)
                        p_reg[i] <= goal_reg[i];
                end
            end
            CMD_SQACC: acc_reg <= acc_reg + prod_reg;
            CMD_FAR:   far_reg <= (acc_reg > prod_reg);
            CMD_ALPHA:
            begin
                delta_reg <= {1'b0, alpha} - {1'b0, last_reg};
                last_reg  <= alpha;
            end
            CMD_SNAP:
            begin
                snapped_reg <= 1'b1;
                for (int i = 0; i < AXES; i++)
                    p_reg[i] <= goal_reg[i];
            end
            CMD_STADD: p_reg[ctl.axis] <= p_reg[ctl.axis] + rnd[FRAC_SH +: POS_BITS];
            CMD_GAIN:
            begin
                if (delay_reg <= GAIN_D_LO)
                    gain_reg <= GAIN_LO;
                else if (delay_reg >= GAIN_D_HI)
                    gain_reg <= GAIN_HI;
                else
                    gain_reg <= GAIN_LO + prod_reg[GAIN_SH +: GAIN_W];
            end
            CMD_EADD:
            begin
                err_reg[ctl.axis]  <= sat_val;
                goal_reg[ctl.axis] <= gin_reg[ctl.axis];
            end
            CMD_GDONE:
            begin
                start_reg <= now_reg;
                last_reg  <= '0;
            end
            CMD_OUT:
            begin
                out_active_reg  <= active_reg;
                out_snapped_reg <= snapped_reg;
                for (int i = 0; i < AXES; i++)
                    out_p_reg[i] <= p_reg[i];
            end
            default: ;
        endcase
    end

    // Result stream packing
    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < AXES; i++)
            m_tdata[i*POS_BITS +: POS_BITS] = out_p_reg[i];
    end

    assign m_tuser  = {out_snapped_reg, out_active_reg};
    assign m_tvalid = m_valid_reg;

    // Status toward the controller
    assign stat.active   = active_reg;
    assign stat.far      = far_reg;
    assign stat.op       = op_reg;
    assign stat.out_busy = m_valid_reg && !m_tready;

endmodule

// ===== rtl/tebs_ctrl.sv =====
// Controller: sequences one item through the datapath.
module tebs_ctrl
    import tebs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output ctl_t  ctl
);

    typedef enum logic [18:0] {
        ST_IDLE   = 19'b0000000000000000001,
        ST_DECODE = 19'b0000000000000000010,
        ST_CLEAR  = 19'b0000000000000000100,
        ST_SQ     = 19'b0000000000000001000,
        ST_SQACC  = 19'b0000000000000010000,
        ST_MD     = 19'b0000000000000100000,
        ST_FAR    = 19'b0000000000001000000,
        ST_TINIT  = 19'b0000000000010000000,
        ST_DIV    = 19'b0000000000100000000,
        ST_ALPHA  = 19'b0000000001000000000,
        ST_SNAP   = 19'b0000000010000000000,
        ST_STMUL  = 19'b0000000100000000000,
        ST_STADD  = 19'b0000001000000000000,
        ST_GINIT  = 19'b0000010000000000000,
        ST_GAIN   = 19'b0000100000000000000,
        ST_EMUL   = 19'b0001000000000000000,
        ST_EADD   = 19'b0010000000000000000,
        ST_GDONE  = 19'b0100000000000000000,
        ST_FIN    = 19'b1000000000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              last_axis;
    logic              is_goal;

    assign last_axis = (axis_reg == AXIS_W'(AXES - 1));
    assign is_goal   = (stat.op == OP_GOAL);

    // Next-state and command logic
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        cnt_next    = cnt_reg;
        ctl.cmd     = CMD_NONE;
        ctl.axis    = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.cmd    = CMD_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                axis_next = '0;
                if (stat.op == OP_SNAP || stat.op == OP_CANCEL)
                    state_next = ST_CLEAR;
                else if (stat.active)
                    state_next = ST_SQ;
                else if (is_goal)
                    state_next = ST_GINIT;
                else
                    state_next = ST_FIN;
            end
            ST_CLEAR:
            begin
                ctl.cmd    = CMD_CLEAR;
                state_next = ST_FIN;
            end
            ST_SQ:
            begin
                ctl.cmd    = CMD_SQ;
                state_next = ST_SQACC;
            end
            ST_SQACC:
            begin
                ctl.cmd = CMD_SQACC;
                if (last_axis)
                begin
                    axis_next  = '0;
                    state_next = ST_MD;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_MD:
            begin
                ctl.cmd    = CMD_MD;
                state_next = ST_FAR;
            end
            ST_FAR:
            begin
                ctl.cmd    = CMD_FAR;
                state_next = ST_TINIT;
            end
            ST_TINIT:
            begin
                ctl.cmd     = CMD_DIVT;
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.cmd  = CMD_DIVSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                    state_next = ST_ALPHA;
            end
            ST_ALPHA:
            begin
                ctl.cmd    = CMD_ALPHA;
                axis_next  = '0;
                state_next = stat.far ? ST_SNAP : ST_STMUL;
            end
            ST_SNAP:
            begin
                ctl.cmd    = CMD_SNAP;
                state_next = is_goal ? ST_GINIT : ST_FIN;
            end
            ST_STMUL:
            begin
                ctl.cmd    = CMD_STMUL;
                state_next = ST_STADD;
            end
            ST_STADD:
            begin
                ctl.cmd = CMD_STADD;
                if (last_axis)
                begin
                    axis_next  = '0;
                    state_next = is_goal ? ST_GINIT : ST_FIN;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_STMUL;
                end
            end
            ST_GINIT:
            begin
                ctl.cmd     = CMD_GMUL;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                ctl.cmd    = CMD_GAIN;
                axis_next  = '0;
                state_next = ST_EMUL;
            end
            ST_EMUL:
            begin
                ctl.cmd    = CMD_EMUL;
                state_next = ST_EADD;
            end
            ST_EADD:
            begin
                ctl.cmd = CMD_EADD;
                if (last_axis)
                begin
                    axis_next  = '0;
                    state_next = ST_GDONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_EMUL;
                end
            end
            ST_GDONE:
            begin
                ctl.cmd    = CMD_GDONE;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    ctl.cmd    = CMD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            axis_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/timed_error_blend_smoother.sv =====
// Top level of the timed error blending position smoother.
//
// Channel  Direction  Handshake              Content
// s_*      in         s_tvalid / s_tready    op, time, position, goal
// m_*      out        m_tvalid / m_tready    new position, blending, snapped
// cfg_*    in         cfg_valid / cfg_ready  register index and value
//
// One item is in work at a time; during a blend the time from one input transaction to
// the next is set mostly by the 48-step restoring divider for alpha; the gain comes
// from the shared multiplier.
// The output register lets the next item enter while a result waits to be taken.
// Reset is asynchronous and restores the register defaults; cfg_ready is always high.
module timed_error_blend_smoother
    import tebs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,    // now_ticks, pos_x, pos_y, pos_z, goal_x, goal_y, goal_z
    input  logic [OP_W-1:0]       s_tuser,    // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // new_x, new_y, new_z
    output logic [OUT_USER_W-1:0] m_tuser,    // blending, snapped
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [DIST_W-1:0]     cfg_data
);

    ctl_t  ctl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    tebs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Arithmetic and state
    tebs_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/tebs_checker.sv =====
// Port-level assertions for the smoother and their bind to the top level.
module tebs_checker
    import tebs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only one item is in work: input closes right after a transaction.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // A result never appears in the cycle right after an input transaction.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind timed_error_blend_smoother tebs_checker u_tebs_checker (.*);
